FILE: design/multilevel_priority_run_queue_core_assert.svh
// Assertion macros for the multilevel priority run queue.
// Included by the top level; depends on nothing else.
`ifndef MULTILEVEL_PRIORITY_RUN_QUEUE_CORE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_RUN_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/mpq_pkg.sv
// Shared types and constants of the multilevel priority run queue.
// No dependencies.
`default_nettype none

package mpq_pkg;

   localparam int DefNumSlots     = 64;
   localparam int DefNumLevels    = 6;
   localparam int OpcodeWidth     = 2;
   localparam int SlotFieldWidth  = 6;
   localparam int LevelFieldWidth = 3;
   localparam int CodeWidth       = 2;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_ENQUEUE   = 2'd0,
      OP_DEQUEUE   = 2'd1,
      OP_SET_STATE = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   typedef enum logic [CodeWidth-1:0] {
      RES_DONE    = 2'd0,
      RES_REFUSED = 2'd1,
      RES_EMPTY   = 2'd2
   } res_type;

   // Per-slot status marks held in the flag memory
   typedef struct packed {
      logic queued;
      logic blocked;
      logic quit;
   } flag_type;

endpackage

`default_nettype wire

FILE: design/mpq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on mpq_pkg for the field widths.
`default_nettype none

interface mpq_req_if import mpq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OpcodeWidth-1:0]     opcode;
   logic [SlotFieldWidth-1:0]  slot_index;
   logic [LevelFieldWidth-1:0] level;
   logic                       blocked_mark;
   logic                       quit_mark;

   modport source (output valid, opcode, slot_index, level, blocked_mark, quit_mark,
                   input ready);
   modport sink   (input valid, opcode, slot_index, level, blocked_mark, quit_mark,
                   output ready);
endinterface

interface mpq_rsp_if import mpq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CodeWidth-1:0]       result_code;
   logic [SlotFieldWidth-1:0]  result_slot;
   logic [LevelFieldWidth-1:0] result_level;

   modport source (output valid, result_code, result_slot, result_level, input ready);
   modport sink   (input valid, result_code, result_slot, result_level, output ready);
endinterface

`default_nettype wire

FILE: design/multilevel_priority_run_queue_core.sv
// Multilevel priority run queue: per-level FIFOs of process slots.
// Depends on mpq_pkg, mpq_if and multilevel_priority_run_queue_core_assert.svh.
//
//   channel   direction  transfer carries
//   req_chan  in         opcode, slot_index, level, blocked_mark, quit_mark
//   rsp_chan  out        result_code, result_slot, result_level
//
// One item is worked on at a time, through the single read port of the slot
// memories (flags and next links, registered read).
// Enqueue and set_state read the slot's flags, then write them; an
// out-of-range slot (or, for enqueue, level) skips both. No-op goes straight
// to the result. Dequeue scans the levels in order, dropping each blocked or
// quit head it meets, until it pops a runnable head or finds nothing runnable.
// After reset the flag memory is cleared slot by slot; req_chan is
// not ready meanwhile. A stalled result waits in the output register while
// the next request is taken.
`default_nettype none

`include "multilevel_priority_run_queue_core_assert.svh"

module multilevel_priority_run_queue_core import mpq_pkg::*; #(
   parameter int NUM_SLOTS  = DefNumSlots,
   parameter int NUM_LEVELS = DefNumLevels
) (
   input  wire       clock,
   input  wire       reset,
   mpq_req_if.sink   req_chan,
   mpq_rsp_if.source rsp_chan
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ENQ_RD,
      ST_ENQ_WR,
      ST_DQ_LEVEL,
      ST_DQ_HEAD,
      ST_SET_RD,
      ST_SET_WR,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [SW-1:0]              clr_ff, clr_in;
   logic [SlotFieldWidth-1:0]  slot_ff, slot_in;
   logic [LevelFieldWidth-1:0] lvl_ff, lvl_in;
   logic                       bmark_ff, bmark_in;
   logic                       qmark_ff, qmark_in;
   logic [LW-1:0]              lv_ff, lv_in;
   logic [SW-1:0]              head_ff [NUM_LEVELS];
   logic [SW-1:0]              head_in [NUM_LEVELS];
   logic [SW-1:0]              tail_ff [NUM_LEVELS];
   logic [SW-1:0]              tail_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0]      hvalid_ff, hvalid_in;
   res_type                    res_code_ff, res_code_in;
   logic [SlotFieldWidth-1:0]  res_slot_ff, res_slot_in;
   logic [LevelFieldWidth-1:0] res_level_ff, res_level_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   res_type                    rsp_code_ff, rsp_code_in;
   logic [SlotFieldWidth-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [LevelFieldWidth-1:0] rsp_level_ff, rsp_level_in;

   // Slot memories
   flag_type                   flags_mem [NUM_SLOTS];
   logic [SW-1:0]              next_mem  [NUM_SLOTS];
   flag_type                   flags_rd_ff;
   logic [SW-1:0]              next_rd_ff;
   logic [SW-1:0]              rd_addr;
   logic                       flags_we;
   logic [SW-1:0]              flags_wa;
   flag_type                   flags_wd;
   logic                       next_we;
   logic [SW-1:0]              next_wa;
   logic [SW-1:0]              next_wd;

   logic                       slot_ok;
   logic                       level_ok;
   logic [SW-1:0]              slot_addr;
   logic [SW-1:0]              cur_head;

   assign slot_ok   = 32'(slot_ff) < NUM_SLOTS;
   assign level_ok  = (lvl_ff != '0) && (32'(lvl_ff) <= NUM_LEVELS);
   assign slot_addr = SW'(slot_ff);
   assign cur_head  = head_ff[lv_ff];

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_code  = rsp_code_ff;
   assign rsp_chan.result_slot  = rsp_slot_ff;
   assign rsp_chan.result_level = rsp_level_ff;

   // Write and read the slot memories
   always_ff @(posedge clock) begin
      if (flags_we) begin
         flags_mem[flags_wa] <= flags_wd;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      flags_rd_ff <= flags_mem[rd_addr];
      next_rd_ff  <= next_mem[rd_addr];
   end

   // Sequence one item through the memories
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      lvl_in       = lvl_ff;
      bmark_in     = bmark_ff;
      qmark_in     = qmark_ff;
      lv_in        = lv_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      hvalid_in    = hvalid_ff;
      res_code_in  = res_code_ff;
      res_slot_in  = res_slot_ff;
      res_level_in = res_level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_level_in = rsp_level_ff;
      rd_addr      = '0;
      flags_we     = 1'b0;
      flags_wa     = '0;
      flags_wd     = '0;
      next_we      = 1'b0;
      next_wa      = '0;
      next_wd      = '0;

      // Drop the output once transferred
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            flags_we = 1'b1;
            flags_wa = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == SW'(NUM_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               slot_in      = req_chan.slot_index;
               lvl_in       = req_chan.level;
               bmark_in     = req_chan.blocked_mark;
               qmark_in     = req_chan.quit_mark;
               lv_in        = '0;
               res_code_in  = RES_DONE;
               res_slot_in  = '0;
               res_level_in = '0;
               case (op_type'(req_chan.opcode))
                  OP_ENQUEUE:   state_in = ST_ENQ_RD;
                  OP_DEQUEUE:   state_in = ST_DQ_LEVEL;
                  OP_SET_STATE: state_in = ST_SET_RD;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_ENQ_RD: begin
            if (slot_ok && level_ok) begin
               rd_addr  = slot_addr;
               lv_in    = LW'(lvl_ff - 1'b1);
               state_in = ST_ENQ_WR;
            end else begin
               res_code_in = RES_REFUSED;
               state_in    = ST_DONE;
            end
         end
         ST_ENQ_WR: begin
            if (flags_rd_ff.blocked || flags_rd_ff.queued) begin
               res_code_in = RES_REFUSED;
            end else begin
               // Mark queued and append at the tail
               flags_we        = 1'b1;
               flags_wa        = slot_addr;
               flags_wd        = flags_rd_ff;
               flags_wd.queued = 1'b1;
               if (hvalid_ff[lv_ff]) begin
                  next_we = 1'b1;
                  next_wa = tail_ff[lv_ff];
                  next_wd = slot_addr;
               end else begin
                  head_in[lv_ff]   = slot_addr;
                  hvalid_in[lv_ff] = 1'b1;
               end
               tail_in[lv_ff] = slot_addr;
            end
            state_in = ST_DONE;
         end
         ST_DQ_LEVEL: begin
            if (hvalid_ff[lv_ff]) begin
               rd_addr  = cur_head;
               state_in = ST_DQ_HEAD;
            end else if (lv_ff == LW'(NUM_LEVELS - 1)) begin
               res_code_in = RES_EMPTY;
               state_in    = ST_DONE;
            end else begin
               lv_in = lv_ff + 1'b1;
            end
         end
         ST_DQ_HEAD: begin
            // Unlink the head and clear its queued mark
            flags_we        = 1'b1;
            flags_wa        = cur_head;
            flags_wd        = flags_rd_ff;
            flags_wd.queued = 1'b0;
            if (cur_head == tail_ff[lv_ff]) begin
               hvalid_in[lv_ff] = 1'b0;
            end else begin
               head_in[lv_ff] = next_rd_ff;
            end
            if (!flags_rd_ff.blocked && !flags_rd_ff.quit) begin
               res_code_in  = RES_DONE;
               res_slot_in  = SlotFieldWidth'(cur_head);
               res_level_in = LevelFieldWidth'(32'(lv_ff) + 1);
               state_in     = ST_DONE;
            end else begin
               state_in = ST_DQ_LEVEL;
            end
         end
         ST_SET_RD: begin
            if (slot_ok) begin
               rd_addr  = slot_addr;
               state_in = ST_SET_WR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SET_WR: begin
            flags_we         = 1'b1;
            flags_wa         = slot_addr;
            flags_wd.queued  = flags_rd_ff.queued;
            flags_wd.blocked = bmark_ff;
            flags_wd.quit    = qmark_ff;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_level_in = res_level_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff      <= slot_in;
      lvl_ff       <= lvl_in;
      bmark_ff     <= bmark_in;
      qmark_ff     <= qmark_in;
      lv_ff        <= lv_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      res_code_ff  <= res_code_in;
      res_slot_ff  <= res_slot_in;
      res_level_ff <= res_level_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_level_ff <= rsp_level_in;
   end

   // One item in flight: a transfer closes the request side
   `MPQ_ASSERT_NEXT(a_busy_after_transfer, clock, reset,
      req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while busy")

   // An enqueue only links a slot that is neither blocked nor queued
   `MPQ_ASSERT_SAME(a_enqueue_legal, clock, reset,
      flags_we && state_ff == ST_ENQ_WR,
      !flags_rd_ff.blocked && !flags_rd_ff.queued, "blocked or queued slot linked")

   // A finished item reaches the output register when it is free
   `MPQ_ASSERT_NEXT(a_result_delivered, clock, reset,
      state_ff == ST_DONE && !rsp_valid_ff, rsp_valid_ff && state_ff == ST_IDLE,
      "result not delivered")

endmodule

`default_nettype wire
